// File: src/cbez_pkg.sv
// shared constants, types and command/status bundles for the bezier evaluator
package cbez_pkg;

    localparam int T_FRAC_BITS        = 16;
    localparam int T_W                = T_FRAC_BITS + 1;
    localparam int COORD_W            = 32;
    localparam int TOL_W              = 31;
    localparam int NUM_COORDS         = 8;
    localparam int REG_IDX_W          = 3;
    localparam int MA_W               = COORD_W + 1;
    localparam int MB_W               = T_W + 1;
    localparam int PROD_W             = MA_W + MB_W;
    localparam int DEFAULT_ITERATIONS = 16;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MID,
        S_UU,
        S_TT,
        S_W0,
        S_W1,
        S_W2,
        S_W3,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_ACC,
        S_ROUND,
        S_CHECK,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_UU,
        MUL_TT,
        MUL_W0,
        MUL_W1,
        MUL_W2,
        MUL_W3,
        MUL_P0,
        MUL_P1,
        MUL_P2,
        MUL_P3
    } mul_op_t;

    typedef struct packed {
        mul_op_t mul_op;
        logic    sel_z;
        logic    load;
        logic    mid_load;
        logic    check;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic hit;
        logic below;
        logic above;
    } status_t;

endpackage

// File: src/cbez_dp.sv
// datapath: coordinate registers, shared multiplier, accumulator and search registers
module cbez_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cbez_pkg::cmd_t                  cmd,
    output cbez_pkg::status_t               status,
    input  logic                            kind,
    input  logic [cbez_pkg::T_W-1:0]        param_t,
    input  logic [cbez_pkg::COORD_W-1:0]    target_z,
    input  logic [cbez_pkg::T_W-1:0]        lower_t,
    input  logic [cbez_pkg::T_W-1:0]        upper_t,
    input  logic [cbez_pkg::TOL_W-1:0]      tolerance,
    input  logic                            cfg_we,
    input  logic [cbez_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [cbez_pkg::COORD_W-1:0]    cfg_data,
    output logic [cbez_pkg::COORD_W-1:0]    x_value,
    output logic [cbez_pkg::T_W-1:0]        t_found,
    output logic                            converged
);
    import cbez_pkg::*;

    localparam int CMP_W = COORD_W + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

    function automatic logic [T_W-1:0] clamp_t(input logic [T_W-1:0] v);
        return (v > T_ONE) ? T_ONE : v;
    endfunction

    function automatic logic signed [MA_W-1:0] ext_t(input logic [T_W-1:0] v);
        return $signed({{(MA_W - T_W){1'b0}}, v});
    endfunction

    function automatic logic signed [MB_W-1:0] ext_w(input logic [T_W-1:0] v);
        return $signed({1'b0, v});
    endfunction

    logic [COORD_W-1:0]         coord_reg [NUM_COORDS];
    logic                       kind_reg;
    logic [T_W-1:0]             t_reg;
    logic [T_W-1:0]             lo_reg;
    logic [T_W-1:0]             hi_reg;
    logic [COORD_W-1:0]         target_reg;
    logic [TOL_W-1:0]           tol_reg;
    logic                       conv_reg;
    logic [T_W-1:0]             uu_reg;
    logic [T_W-1:0]             tt_reg;
    logic [T_W-1:0]             w0_reg;
    logic [T_W-1:0]             w1_reg;
    logic [T_W-1:0]             w2_reg;
    logic [T_W-1:0]             w3_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    mul_op_t                    op_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic [COORD_W-1:0]         eval_reg;
    logic [COORD_W-1:0]         eval_next;
    logic [COORD_W-1:0]         x_value_reg;
    logic [T_W-1:0]             t_found_reg;
    logic                       converged_reg;

    logic [T_W-1:0]             u_val;
    logic [T_W:0]               mid_sum;
    logic [T_W-1:0]             scaled;
    logic [T_W:0]               triple;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic [REG_IDX_W-1:0]       coord_sel;
    logic [COORD_W-1:0]         coord_val;
    logic signed [PROD_W-1:0]   round_sum;
    logic signed [PROD_W-1:0]   shifted;
    logic signed [CMP_W-1:0]    z_ext;
    logic signed [CMP_W-1:0]    tgt_ext;
    logic signed [CMP_W-1:0]    tol_ext;
    logic signed [CMP_W-1:0]    upper_bound;
    logic signed [CMP_W-1:0]    lower_bound;

    assign u_val   = T_ONE - t_reg;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign scaled  = prod_reg[T_FRAC_BITS +: T_W];
    assign triple  = {1'b0, scaled} + {scaled, 1'b0};

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        coord_sel = {cmd.sel_z, 2'd0};
        unique case (cmd.mul_op)
            MUL_UU:
            begin
                mul_a = ext_t(u_val);
                mul_b = ext_w(u_val);
            end
            MUL_TT:
            begin
                mul_a = ext_t(t_reg);
                mul_b = ext_w(t_reg);
            end
            MUL_W0:
            begin
                mul_a = ext_t(uu_reg);
                mul_b = ext_w(u_val);
            end
            MUL_W1:
            begin
                mul_a = ext_t(uu_reg);
                mul_b = ext_w(t_reg);
            end
            MUL_W2:
            begin
                mul_a = ext_t(tt_reg);
                mul_b = ext_w(u_val);
            end
            MUL_W3:
            begin
                mul_a = ext_t(tt_reg);
                mul_b = ext_w(t_reg);
            end
            MUL_P0:
            begin
                coord_sel = {cmd.sel_z, 2'd0};
                mul_b     = ext_w(w0_reg);
            end
            MUL_P1:
            begin
                coord_sel = {cmd.sel_z, 2'd1};
                mul_b     = ext_w(w1_reg);
            end
            MUL_P2:
            begin
                coord_sel = {cmd.sel_z, 2'd2};
                mul_b     = ext_w(w2_reg);
            end
            MUL_P3:
            begin
                coord_sel = {cmd.sel_z, 2'd3};
                mul_b     = ext_w(w3_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        coord_val = coord_reg[coord_sel];
        if (cmd.mul_op == MUL_P0 || cmd.mul_op == MUL_P1 ||
            cmd.mul_op == MUL_P2 || cmd.mul_op == MUL_P3)
        begin
            mul_a = $signed({coord_val[COORD_W-1], coord_val});
        end
    end

    assign prod_next = mul_a * mul_b;

    // round half up, then saturate to 32 signed bits
    always_comb
    begin
        round_sum = acc_reg + HALF;
        shifted   = round_sum >>> T_FRAC_BITS;
        if (&shifted[PROD_W-1:COORD_W-1] || ~|shifted[PROD_W-1:COORD_W-1])
        begin
            eval_next = shifted[COORD_W-1:0];
        end
        else if (shifted[PROD_W-1])
        begin
            eval_next = {1'b1, {(COORD_W - 1){1'b0}}};
        end
        else
        begin
            eval_next = {1'b0, {(COORD_W - 1){1'b1}}};
        end
    end

    // tolerance window, wide enough that nothing overflows
    always_comb
    begin
        z_ext       = $signed({{2{eval_reg[COORD_W-1]}}, eval_reg});
        tgt_ext     = $signed({{2{target_reg[COORD_W-1]}}, target_reg});
        tol_ext     = $signed({{(CMP_W - TOL_W){1'b0}}, tol_reg});
        upper_bound = tgt_ext + tol_ext;
        lower_bound = tgt_ext - tol_ext;
    end

    assign status.kind  = kind_reg;
    assign status.hit   = (z_ext < upper_bound) && (z_ext > lower_bound);
    assign status.below = z_ext < tgt_ext;
    assign status.above = z_ext > tgt_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                coord_reg[i] <= '0;
            end
            op_reg <= MUL_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                coord_reg[cfg_index] <= cfg_data;
            end
            op_reg <= cmd.mul_op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;

        // product of the previous cycle lands in its destination
        unique case (op_reg)
            MUL_UU:  uu_reg  <= scaled;
            MUL_TT:  tt_reg  <= scaled;
            MUL_W0:  w0_reg  <= scaled;
            MUL_W1:  w1_reg  <= triple[T_W-1:0];
            MUL_W2:  w2_reg  <= triple[T_W-1:0];
            MUL_W3:  w3_reg  <= scaled;
            MUL_P0:  acc_reg <= prod_reg;
            MUL_P1:  acc_reg <= acc_reg + prod_reg;
            MUL_P2:  acc_reg <= acc_reg + prod_reg;
            MUL_P3:  acc_reg <= acc_reg + prod_reg;
            default: acc_reg <= acc_reg;
        endcase

        eval_reg <= eval_next;

        if (cmd.load)
        begin
            kind_reg   <= kind;
            t_reg      <= clamp_t(param_t);
            lo_reg     <= clamp_t(lower_t);
            hi_reg     <= clamp_t(upper_t);
            target_reg <= target_z;
            tol_reg    <= tolerance;
            conv_reg   <= ~kind;
        end
        else if (cmd.mid_load)
        begin
            t_reg <= mid_sum[T_W:1];
        end
        else if (cmd.check)
        begin
            if (status.hit)
            begin
                conv_reg <= 1'b1;
            end
            else if (status.below)
            begin
                lo_reg <= t_reg;
            end
            else if (status.above)
            begin
                hi_reg <= t_reg;
            end
        end

        if (cmd.out_load)
        begin
            x_value_reg   <= eval_reg;
            t_found_reg   <= t_reg;
            converged_reg <= conv_reg;
        end
    end

    assign x_value   = x_value_reg;
    assign t_found   = t_found_reg;
    assign converged = converged_reg;

endmodule

// File: src/cbez_ctrl.sv
// controller: sequences the multiplier schedule, bisection steps and output handshake
module cbez_ctrl #(
    parameter int ITERATIONS = cbez_pkg::DEFAULT_ITERATIONS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cbez_pkg::cmd_t    cmd,
    input  cbez_pkg::status_t status
);
    import cbez_pkg::*;

    localparam int IW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam logic [IW-1:0] LAST_ITER = IW'(ITERATIONS - 1);

    state_t         state_reg;
    state_t         state_next;
    logic [IW-1:0]  iter_reg;
    logic [IW-1:0]  iter_next;
    logic           eval_z_reg;
    logic           eval_z_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           search_done;

    assign search_done = status.hit || !(status.below || status.above) || (iter_reg == LAST_ITER);

    always_comb
    begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        eval_z_next = eval_z_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MID;
                    iter_next  = '0;
                end
            end
            S_MID:
            begin
                state_next  = S_UU;
                eval_z_next = status.kind;
            end
            S_UU:    state_next = S_TT;
            S_TT:    state_next = S_W0;
            S_W0:    state_next = S_W1;
            S_W1:    state_next = S_W2;
            S_W2:    state_next = S_W3;
            S_W3:    state_next = S_P0;
            S_P0:    state_next = S_P1;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_P3;
            S_P3:    state_next = S_ACC;
            S_ACC:   state_next = S_ROUND;
            S_ROUND: state_next = eval_z_reg ? S_CHECK : S_OUT;
            S_CHECK:
            begin
                if (search_done)
                begin
                    // final x evaluation at the last midpoint
                    state_next  = S_UU;
                    eval_z_next = 1'b0;
                end
                else
                begin
                    state_next = S_MID;
                    iter_next  = iter_reg + IW'(1);
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_op   = MUL_NONE;
        cmd.sel_z    = eval_z_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_MID:   cmd.mid_load = status.kind;
            S_UU:    cmd.mul_op = MUL_UU;
            S_TT:    cmd.mul_op = MUL_TT;
            S_W0:    cmd.mul_op = MUL_W0;
            S_W1:    cmd.mul_op = MUL_W1;
            S_W2:    cmd.mul_op = MUL_W2;
            S_W3:    cmd.mul_op = MUL_W3;
            S_P0:    cmd.mul_op = MUL_P0;
            S_P1:    cmd.mul_op = MUL_P1;
            S_P2:    cmd.mul_op = MUL_P2;
            S_P3:    cmd.mul_op = MUL_P3;
            S_CHECK: cmd.check = 1'b1;
            S_OUT:   cmd.out_load = !out_valid_reg || out_ready;
            default: cmd.mul_op = MUL_NONE;
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            eval_z_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            eval_z_reg    <= eval_z_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iter_reg <= LAST_ITER)
        else $error("bisection counter past last step");

    a_accept_to_mid: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_MID)
        else $error("accepted beat did not start a job");

    a_check_only_z: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> eval_z_reg)
        else $error("tolerance check on an x evaluation");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result beat raised outside output state");
`endif

endmodule

// File: src/cubic_bezier_eval_and_inverse.sv
// top level: cubic bezier x evaluation and bisection search on z
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   kind, param_t, target_z, lower_t, upper_t, tolerance
// out       output     out_valid / out_ready x_value, t_found, converged
// cfg       input      cfg_we                cfg_index, cfg_data
//
// one cubic evaluation runs ten products on the single 33x18 multiplier
// kind 0: one x evaluation from accept to result; kind 1: one z evaluation per
// bisection step, then an x evaluation at the last midpoint, with up to 16 steps
// rst_n clears the coordinate registers, the controller state and out_valid
// a held result beat does not block the next accept; the next result waits for it
module cubic_bezier_eval_and_inverse #(
    parameter int ITERATIONS = cbez_pkg::DEFAULT_ITERATIONS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [cbez_pkg::T_W-1:0]        param_t,
    input  logic [cbez_pkg::COORD_W-1:0]    target_z,
    input  logic [cbez_pkg::T_W-1:0]        lower_t,
    input  logic [cbez_pkg::T_W-1:0]        upper_t,
    input  logic [cbez_pkg::TOL_W-1:0]      tolerance,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cbez_pkg::COORD_W-1:0]    x_value,
    output logic [cbez_pkg::T_W-1:0]        t_found,
    output logic                            converged,
    input  logic                            cfg_we,
    input  logic [cbez_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [cbez_pkg::COORD_W-1:0]    cfg_data
);
    import cbez_pkg::*;

    cmd_t    cmd;
    status_t status;

    cbez_ctrl #(
        .ITERATIONS (ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    cbez_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (kind),
        .param_t   (param_t),
        .target_z  (target_z),
        .lower_t   (lower_t),
        .upper_t   (upper_t),
        .tolerance (tolerance),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .x_value   (x_value),
        .t_found   (t_found),
        .converged (converged)
    );

endmodule
